// ===== hdl/hvenv_pkg.sv =====
// ============================================================================
// hvenv_pkg: shared types, constants and functions of the harmonic voice
// Holds register codes, controller commands and the quarter-wave sine function.
// ============================================================================
`default_nettype none

package hvenv_pkg;

    // Parameter defaults
    localparam int PHASE_BITS_DEF      = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Register and state widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 24;
    localparam int VOL_W      = 16;
    localparam int DUR_W      = 24;
    localparam int ATK_W      = 16;
    localparam int ASTEP_W    = 17;
    localparam int DECAY_W    = 16;
    localparam int ENV_W      = 17;
    localparam int CNT_W      = 24;
    localparam int SINE_W     = 15;
    localparam int HSUM_W     = 18;
    localparam int MUL_W      = 17;

    // Envelope full scale in Q1.16
    localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

    // Register reset values
    localparam logic [ATK_W-1:0]   ATTACK_SAMPLES_RST = 16'd480;
    localparam logic [ASTEP_W-1:0] ATTACK_STEP_RST    = 17'd136;
    localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST   = 16'd65535;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PHASE_STEP       = 3'd0,
        CFG_VOLUME           = 3'd1,
        CFG_DURATION_SAMPLES = 3'd2,
        CFG_ATTACK_SAMPLES   = 3'd3,
        CFG_ATTACK_STEP      = 3'd4,
        CFG_DECAY_FACTOR     = 3'd5
    } cfg_index_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN0,
        ST_SIN1,
        ST_SIN2,
        ST_ACC,
        ST_MENV,
        ST_MVOL,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Harmonic whose phase addresses the sine table
    typedef enum logic [1:0] {
        HARM_FUND,
        HARM_SECOND,
        HARM_THIRD
    } harm_sel_t;

    // Operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MUL_ENV,
        MUL_VOL,
        MUL_DECAY
    } mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      accept;
        harm_sel_t rom_sel;
        logic      acc_first;
        logic      acc_en;
        mul_sel_t  mul_sel;
        logic      env_mag_ld;
        logic      mag_ld;
        logic      step_voice;
        logic      emit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mix_go;
        logic out_free;
    } ctrl_status_t;

    // Quarter-wave sine in Q15 at table point k of a quarter with 2^qbits steps
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                       input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x5;
        longint unsigned v;
        x  = 64'(k) << (15 - qbits);
        x2 = (x * x) >> 15;
        x3 = (x2 * x) >> 15;
        x5 = (x3 * x2) >> 15;
        v  = (64'd51472 * x - 64'd21167 * x3 + 64'd2611 * x5) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return SINE_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hvenv_ctrl.sv =====
// ============================================================================
// hvenv_ctrl: sequencing controller of the harmonic voice
// Walks each accepted mixed tick through table reads, multiplies and the result.
// ============================================================================
`default_nettype none

module hvenv_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire hvenv_pkg::ctrl_status_t status,
    output hvenv_pkg::ctrl_cmd_t         cmd
);

    hvenv_pkg::state_t state_reg;
    hvenv_pkg::state_t state_next;
    logic              take;

    assign take = s_tvalid && (state_reg == hvenv_pkg::ST_IDLE);

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hvenv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hvenv_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = status.mix_go ? hvenv_pkg::ST_SIN0 : hvenv_pkg::ST_EMIT;
                end
            end
            hvenv_pkg::ST_SIN0: state_next = hvenv_pkg::ST_SIN1;
            hvenv_pkg::ST_SIN1: state_next = hvenv_pkg::ST_SIN2;
            hvenv_pkg::ST_SIN2: state_next = hvenv_pkg::ST_ACC;
            hvenv_pkg::ST_ACC:  state_next = hvenv_pkg::ST_MENV;
            hvenv_pkg::ST_MENV: state_next = hvenv_pkg::ST_MVOL;
            hvenv_pkg::ST_MVOL: state_next = hvenv_pkg::ST_STEP;
            hvenv_pkg::ST_STEP: state_next = hvenv_pkg::ST_EMIT;
            hvenv_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = hvenv_pkg::ST_IDLE;
                end
            end
            default: state_next = hvenv_pkg::ST_IDLE;
        endcase
    end

    // Drive commands for the current state
    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.rom_sel    = hvenv_pkg::HARM_FUND;
        cmd.mul_sel    = hvenv_pkg::MUL_ENV;
        unique case (state_reg)
            hvenv_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = take;
            end
            hvenv_pkg::ST_SIN0:
            begin
                cmd.rom_sel = hvenv_pkg::HARM_FUND;
            end
            hvenv_pkg::ST_SIN1:
            begin
                cmd.rom_sel   = hvenv_pkg::HARM_SECOND;
                cmd.acc_en    = 1'b1;
                cmd.acc_first = 1'b1;
            end
            hvenv_pkg::ST_SIN2:
            begin
                cmd.rom_sel = hvenv_pkg::HARM_THIRD;
                cmd.acc_en  = 1'b1;
            end
            hvenv_pkg::ST_ACC:
            begin
                cmd.acc_en = 1'b1;
            end
            hvenv_pkg::ST_MENV:
            begin
                cmd.mul_sel    = hvenv_pkg::MUL_ENV;
                cmd.env_mag_ld = 1'b1;
            end
            hvenv_pkg::ST_MVOL:
            begin
                cmd.mul_sel = hvenv_pkg::MUL_VOL;
                cmd.mag_ld  = 1'b1;
            end
            hvenv_pkg::ST_STEP:
            begin
                cmd.mul_sel    = hvenv_pkg::MUL_DECAY;
                cmd.step_voice = 1'b1;
            end
            hvenv_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/hvenv_dp.sv =====
// ============================================================================
// hvenv_dp: datapath of the harmonic voice
// Registers, quarter-wave sine table, shared multiplier, envelope and mixer.
// ============================================================================
`default_nettype none

module hvenv_dp #(
    parameter int PHASE_BITS      = hvenv_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = hvenv_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = hvenv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hvenv_pkg::ctrl_cmd_t                cmd,
    output hvenv_pkg::ctrl_status_t                  status,
    input  wire logic                                s_op,
    input  wire logic [SAMPLE_BITS-1:0]              s_sample,
    input  wire logic                                cfg_we,
    input  wire logic [hvenv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [hvenv_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                m_tready,
    output logic                                     out_valid,
    output logic [SAMPLE_BITS-1:0]                   out_sample,
    output logic                                     out_active,
    output logic                                     out_clip
);

    localparam int QBITS  = SINE_TABLE_BITS - 2;
    localparam int QDEPTH = 1 << QBITS;
    localparam int MAG_W  = SAMPLE_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 4;
    localparam int VSHIFT = 31 - SAMPLE_BITS;
    localparam int PROD_W = 2 * hvenv_pkg::MUL_W;
    localparam logic [SINE_TABLE_BITS-2:0] QUARTER_TOP =
        {1'b1, {(SINE_TABLE_BITS-2){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Configuration registers
    logic [hvenv_pkg::STEP_W-1:0]  phase_step_reg;
    logic [hvenv_pkg::VOL_W-1:0]   volume_reg;
    logic [hvenv_pkg::DUR_W-1:0]   duration_reg;
    logic [hvenv_pkg::ATK_W-1:0]   attack_samples_reg;
    logic [hvenv_pkg::ASTEP_W-1:0] attack_step_reg;
    logic [hvenv_pkg::DECAY_W-1:0] decay_factor_reg;

    // Voice state
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [hvenv_pkg::CNT_W-1:0]   elapsed_reg;
    logic [hvenv_pkg::ENV_W-1:0]   env_reg;
    logic                          playing_reg;

    // Item payload and working registers
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          mix_reg;
    logic [hvenv_pkg::SINE_W-1:0]  sine_rd_reg;
    logic                          sine_neg_reg;
    logic signed [hvenv_pkg::HSUM_W-1:0] acc_reg;
    logic [hvenv_pkg::MUL_W-1:0]   env_mag_reg;
    logic [MAG_W-1:0]              mag_reg;

    // Result register
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic                          out_active_reg;
    logic                          out_clip_reg;

    // Sine table
    logic [hvenv_pkg::SINE_W-1:0]  sine_rom [QDEPTH+1];

    logic [PHASE_BITS-1:0]         rom_phase;
    logic [SINE_TABLE_BITS-1:0]    rom_idx;
    logic [SINE_TABLE_BITS-2:0]    rom_pos;
    logic [SINE_TABLE_BITS-2:0]    rom_addr;

    logic signed [hvenv_pkg::HSUM_W-1:0] term;
    logic [hvenv_pkg::MUL_W-1:0]   h_abs;
    logic [hvenv_pkg::MUL_W-1:0]   mul_a;
    logic [hvenv_pkg::MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]             prod;

    logic [hvenv_pkg::CNT_W:0]     elapsed_inc;
    logic [hvenv_pkg::ENV_W:0]     env_add;
    logic [hvenv_pkg::ENV_W-1:0]   env_step;

    logic signed [SUM_W-1:0]       mag_s;
    logic signed [SUM_W-1:0]       mix_sum;
    logic                          mix_hi;
    logic                          mix_lo;
    logic                          out_free;

    // Fill the quarter-wave table, one extra point for the mirrored peak
    for (genvar g = 0; g <= QDEPTH; g++)
    begin : g_rom
        assign sine_rom[g] = hvenv_pkg::quarter_sine(g, QBITS);
    end

    assign out_free = !out_valid_reg || m_tready;

    assign status.mix_go   = !s_op && playing_reg && (elapsed_reg < duration_reg);
    assign status.out_free = out_free;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg     <= '0;
            volume_reg         <= '0;
            duration_reg       <= '0;
            attack_samples_reg <= hvenv_pkg::ATTACK_SAMPLES_RST;
            attack_step_reg    <= hvenv_pkg::ATTACK_STEP_RST;
            decay_factor_reg   <= hvenv_pkg::DECAY_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (hvenv_pkg::cfg_index_t'(cfg_addr))
                hvenv_pkg::CFG_PHASE_STEP:
                    phase_step_reg <= cfg_data[hvenv_pkg::STEP_W-1:0];
                hvenv_pkg::CFG_VOLUME:
                    volume_reg <= cfg_data[hvenv_pkg::VOL_W-1:0];
                hvenv_pkg::CFG_DURATION_SAMPLES:
                    duration_reg <= cfg_data[hvenv_pkg::DUR_W-1:0];
                hvenv_pkg::CFG_ATTACK_SAMPLES:
                    attack_samples_reg <= cfg_data[hvenv_pkg::ATK_W-1:0];
                hvenv_pkg::CFG_ATTACK_STEP:
                    attack_step_reg <= cfg_data[hvenv_pkg::ASTEP_W-1:0];
                hvenv_pkg::CFG_DECAY_FACTOR:
                    decay_factor_reg <= cfg_data[hvenv_pkg::DECAY_W-1:0];
                default:
                begin
                    phase_step_reg <= phase_step_reg;
                end
            endcase
        end
    end

    // Select the harmonic phase and fold it into the quarter table
    always_comb
    begin
        unique case (cmd.rom_sel)
            hvenv_pkg::HARM_FUND:   rom_phase = phase_reg;
            hvenv_pkg::HARM_SECOND: rom_phase = phase_reg << 1;
            hvenv_pkg::HARM_THIRD:  rom_phase = phase_reg + (phase_reg << 1);
            default:                rom_phase = phase_reg;
        endcase
        rom_idx  = rom_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        rom_pos  = {1'b0, rom_idx[SINE_TABLE_BITS-3:0]};
        rom_addr = rom_idx[SINE_TABLE_BITS-2] ? (QUARTER_TOP - rom_pos) : rom_pos;
    end

    // Read the sine table, keep the half-cycle sign beside it
    always_ff @(posedge clk)
    begin
        sine_rd_reg  <= sine_rom[rom_addr];
        sine_neg_reg <= rom_idx[SINE_TABLE_BITS-1];
    end

    // Sum the three harmonics
    always_comb
    begin
        term = signed'(hvenv_pkg::HSUM_W'(sine_rd_reg));
        if (sine_neg_reg)
        begin
            term = -term;
        end
        h_abs = acc_reg[hvenv_pkg::HSUM_W-1] ? hvenv_pkg::MUL_W'(-acc_reg)
                                              : hvenv_pkg::MUL_W'(acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            acc_reg <= cmd.acc_first ? term : (acc_reg + term);
        end
    end

    // Shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            hvenv_pkg::MUL_ENV:
            begin
                mul_a = h_abs;
                mul_b = env_reg;
            end
            hvenv_pkg::MUL_VOL:
            begin
                mul_a = env_mag_reg;
                mul_b = hvenv_pkg::MUL_W'(volume_reg);
            end
            hvenv_pkg::MUL_DECAY:
            begin
                mul_a = env_reg;
                mul_b = hvenv_pkg::MUL_W'(decay_factor_reg);
            end
            default:
            begin
                mul_a = env_reg;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Scale the sine sum by envelope, then by volume
    always_ff @(posedge clk)
    begin
        if (cmd.env_mag_ld)
        begin
            env_mag_reg <= prod[16 +: hvenv_pkg::MUL_W];
        end
        if (cmd.mag_ld)
        begin
            mag_reg <= prod[VSHIFT +: MAG_W];
        end
    end

    // Next envelope after a mixed sample
    always_comb
    begin
        elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
        env_add     = {1'b0, env_reg} + {1'b0, attack_step_reg};
        if (elapsed_inc < (hvenv_pkg::CNT_W+1)'(attack_samples_reg))
        begin
            env_step = (env_add > {1'b0, hvenv_pkg::ENV_ONE}) ? hvenv_pkg::ENV_ONE
                                                              : env_add[hvenv_pkg::ENV_W-1:0];
        end
        else if (elapsed_inc == (hvenv_pkg::CNT_W+1)'(attack_samples_reg))
        begin
            env_step = hvenv_pkg::ENV_ONE;
        end
        else
        begin
            env_step = prod[16 +: hvenv_pkg::ENV_W];
        end
    end

    // Update voice state on start, idle ticks and mixed samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            elapsed_reg <= '0;
            env_reg     <= '0;
            playing_reg <= 1'b0;
            mix_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            mix_reg <= status.mix_go;
            if (s_op)
            begin
                phase_reg   <= '0;
                elapsed_reg <= '0;
                env_reg     <= (attack_samples_reg == '0) ? hvenv_pkg::ENV_ONE : '0;
                playing_reg <= 1'b1;
            end
            else if (!status.mix_go)
            begin
                playing_reg <= 1'b0;
            end
        end
        else if (cmd.step_voice)
        begin
            phase_reg   <= phase_reg + PHASE_BITS'(phase_step_reg);
            elapsed_reg <= elapsed_inc[hvenv_pkg::CNT_W-1:0];
            env_reg     <= env_step;
            if (elapsed_inc[hvenv_pkg::CNT_W-1:0] >= duration_reg)
            begin
                playing_reg <= 1'b0;
            end
        end
    end

    // Capture the incoming sample
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= signed'(s_sample);
        end
    end

    // Mix and saturate
    always_comb
    begin
        mag_s   = signed'(SUM_W'(mag_reg));
        mix_sum = acc_reg[hvenv_pkg::HSUM_W-1] ? (SUM_W'(sample_reg) - mag_s)
                                                : (SUM_W'(sample_reg) + mag_s);
        mix_hi  = mix_sum > SAT_HI;
        mix_lo  = mix_sum < SAT_LO;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_active_reg <= mix_reg;
            out_clip_reg   <= mix_reg && (mix_hi || mix_lo);
            if (!mix_reg)
            begin
                out_sample_reg <= sample_reg;
            end
            else if (mix_hi)
            begin
                out_sample_reg <= SAT_HI[SAMPLE_BITS-1:0];
            end
            else if (mix_lo)
            begin
                out_sample_reg <= SAT_LO[SAMPLE_BITS-1:0];
            end
            else
            begin
                out_sample_reg <= mix_sum[SAMPLE_BITS-1:0];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_active = out_active_reg;
    assign out_clip   = out_clip_reg;

endmodule

`default_nettype wire

// ===== hdl/harmonic_voice_with_envelope_core.sv =====
// ============================================================================
// harmonic_voice_with_envelope_core: one additive synth voice mixed into audio
// Top level joining the sequencing controller and the voice datapath.
// ============================================================================
// Each input item is either a start command (tuser = 1) or a sample tick
// (tuser = 0) carrying the existing mix sample; every item returns exactly
// one result. Start commands, ticks while the voice is silent and ticks after
// the note has ended go from acceptance straight to writing the result. A
// mixed tick takes three reads of the single quarter-wave sine table, one per
// harmonic, a step to finish the sum, three passes through one shared 17x17
// multiplier (envelope, volume, decay) and a step to write the result. The
// next item is accepted only after the current one has been written to the
// output register, so the input waits while a result is held back by the
// output side. Configuration writes take effect on the next item and must be
// made while no item is in flight.
`default_nettype none

module harmonic_voice_with_envelope_core #(
    parameter int PHASE_BITS      = hvenv_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = hvenv_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = hvenv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,  // in_sample
    input  wire logic [0:0]                        s_tuser,  // op
    // Result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // out_sample
    output logic [1:0]                             m_tuser,  // clipped, active
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [hvenv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [hvenv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    hvenv_pkg::ctrl_cmd_t    cmd;
    hvenv_pkg::ctrl_status_t status;
    logic [SAMPLE_BITS-1:0]  out_sample;
    logic                    out_active;
    logic                    out_clip;

    hvenv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hvenv_dp #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_op       (s_tuser[0]),
        .s_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (out_sample),
        .out_active (out_active),
        .out_clip   (out_clip)
    );

    // Pack the result item
    assign m_tdata = TDATA_W'(out_sample);
    assign m_tuser = {out_clip, out_active};

endmodule

`default_nettype wire

// ===== hdl/hvenv_checker.sv =====
// ============================================================================
// hvenv_checker: port-level assertions for the harmonic voice
// Watches handshakes and result flags of the top level; bound to it below.
// ============================================================================
`default_nettype none

module hvenv_checker #(
    parameter int SAMPLE_BITS = hvenv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic [1:0]                       m_tuser
);

    localparam logic [SAMPLE_BITS-1:0] RAIL_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] RAIL_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // One item in flight: input closes after an item is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an item was taken");

    // A new result appears only while the input side is closed
    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without an item in flight");

    // Clipping only on a mixed sample, and then at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] &&
            (m_tdata[SAMPLE_BITS-1:0] == RAIL_HI || m_tdata[SAMPLE_BITS-1:0] == RAIL_LO))
    else $error("clipped flag without saturated mixed sample");

endmodule

bind harmonic_voice_with_envelope_core hvenv_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_hvenv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
